// ----- design/tilt_flip_activation_controller_assert.svh -----
// Assertion macros for the tilt flip activation controller.
// Used by the top level; no other dependencies.
`ifndef TILT_FLIP_ACTIVATION_CONTROLLER_ASSERT_SVH
`define TILT_FLIP_ACTIVATION_CONTROLLER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define TFAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tfac assertion failed");
// next-cycle implication
`define TFAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tfac assertion failed");
`else
`define TFAC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TFAC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/tfac_pkg.sv -----
// Shared types and codes for the tilt flip activation controller.
// No dependencies.
`timescale 1ns / 1ps

package tfac_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_WINDOW_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REARM_WINDOW_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENROLL_WINDOW_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TIMEOUT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ACTIVE_TIME  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTDOWN_START   = 3'd5;

    // mode actions
    localparam logic [3:0] MODE_NONE             = 4'd0;
    localparam logic [3:0] MODE_ENTERED_UP_WORK  = 4'd1;
    localparam logic [3:0] MODE_ENTERING_UP      = 4'd2;
    localparam logic [3:0] MODE_UP_ACTIVE        = 4'd3;
    localparam logic [3:0] MODE_UP_SLEEP         = 4'd4;
    localparam logic [3:0] MODE_KEEP_ACTIVE      = 4'd5;
    localparam logic [3:0] MODE_ENTERING_DOWN    = 4'd6;
    localparam logic [3:0] MODE_ENTERED_DOWN     = 4'd7;
    localparam logic [3:0] MODE_DOWN_SLEEP       = 4'd8;

    // background steps
    localparam logic [1:0] BG_NONE   = 2'd0;
    localparam logic [1:0] BG_WARN   = 2'd1;
    localparam logic [1:0] BG_REINIT = 2'd2;

    // flag writes
    localparam logic [1:0] FW_NONE  = 2'd0;
    localparam logic [1:0] FW_CLEAR = 2'd1;
    localparam logic [1:0] FW_SET   = 2'd2;

    localparam logic [TIME_W-1:0] FLIP_TIME_RESET = 32'hFFFF_FF9C;

    typedef struct packed {
        logic [7:0]  flip_window_min;
        logic [7:0]  rearm_window_max;
        logic [7:0]  enroll_window_max;
        logic [15:0] sleep_timeout;
        logic [15:0] keep_active_time;
        logic [1:0]  countdown_start;
    } t_cfg;

    typedef struct packed {
        logic push;
        logic clear;
    } t_hist_ctrl;

endpackage

// ----- design/tilt_flip_activation_controller.sv -----
// Channel   Direction  Signals
// poll      in         i_valid / o_stall, i_switch_open ... i_stored_enrolled
// result    out        o_valid / i_stall, o_mode_action ... o_inverted_now
// config    in         i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data
//
// One poll per cycle sustained while the result is not stalled; a poll passes the
// input register, then the decision logic and state update into the result register.
// Reset (synchronous, active low) clears flags, timer, countdown and loads the
// flip history with -100 and the config registers with their defaults.
// A stalled result holds; the input register keeps taking polls until it too
// is full. Config writes are always ready.
// Depends on tfac_pkg, tfac_cfg_regs, tfac_history and the assertion header.
`timescale 1ns / 1ps
`include "tilt_flip_activation_controller_assert.svh"

module tilt_flip_activation_controller #(
    parameter int HISTORY_DEPTH = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_switch_open,
    input  logic                            i_switch_open_confirm,
    input  logic [31:0]                     i_now_seconds,
    input  logic                            i_stored_enrolled,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [3:0]                      o_mode_action,
    output logic                            o_entered_down_work,
    output logic                            o_short_beep,
    output logic [1:0]                      o_background_step,
    output logic [1:0]                      o_flag_write,
    output logic                            o_active_now,
    output logic                            o_inverted_now,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tfac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tfac_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tfac_pkg::t_cfg       cfg;
    tfac_pkg::t_hist_ctrl hist_ctrl;
    logic signed [31:0]   span;

    // input register
    logic        r_in_valid;
    logic        r_in_open;
    logic        r_in_confirm;
    logic [31:0] r_in_now;
    logic        r_in_enrolled;

    // block state
    logic        r_active, n_active;
    logic        r_inverted, n_inverted;
    logic [31:0] r_last_up, n_last_up;
    logic [1:0]  r_countdown, n_countdown;

    // result register
    logic        r_out_valid;
    logic [3:0]  r_mode, n_mode;
    logic        r_down_work, n_down_work;
    logic        r_beep, n_beep;
    logic [1:0]  r_bg, n_bg;
    logic [1:0]  r_fw, n_fw;
    logic        r_active_now;
    logic        r_inverted_now;

    logic fire;
    logic accept;
    logic span_above_min;
    logic rearm_ok;
    logic enroll_ok;
    logic [31:0] sleep_at;
    logic [31:0] keep_until;

    assign o_cfg_ready = 1'b1;

    tfac_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    tfac_history #(
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (hist_ctrl),
        .i_now   (r_in_now),
        .o_span  (span)
    );

    assign fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !fire;
    assign accept  = i_valid && !o_stall;

    assign span_above_min = span > $signed({24'd0, cfg.flip_window_min});
    assign rearm_ok       = span_above_min && (span < $signed({24'd0, cfg.rearm_window_max}));
    assign enroll_ok      = span_above_min && (span < $signed({24'd0, cfg.enroll_window_max}));
    assign sleep_at       = r_last_up + {16'd0, cfg.sleep_timeout};
    assign keep_until     = r_last_up + {16'd0, cfg.keep_active_time};

    always_comb begin
        n_active     = r_active;
        n_inverted   = r_inverted;
        n_last_up    = r_last_up;
        n_countdown  = r_countdown;
        n_mode       = tfac_pkg::MODE_NONE;
        n_down_work  = 1'b0;
        n_beep       = 1'b0;
        n_bg         = tfac_pkg::BG_NONE;
        n_fw         = tfac_pkg::FW_NONE;
        hist_ctrl    = '0;

        if (r_in_open) begin
            if (r_inverted) begin
                // flip to upright counts only if the re-read agrees
                if (r_in_confirm) begin
                    hist_ctrl.push = fire;
                    n_inverted     = 1'b0;
                    if (r_in_enrolled) begin
                        n_active = 1'b1;
                        if (rearm_ok) begin
                            n_countdown     = cfg.countdown_start;
                            hist_ctrl.clear = fire;
                        end
                    end else if (enroll_ok) begin
                        n_fw            = tfac_pkg::FW_SET;
                        hist_ctrl.clear = fire;
                    end else begin
                        n_active = 1'b0;
                    end
                    n_mode = n_active ? tfac_pkg::MODE_ENTERED_UP_WORK
                                      : tfac_pkg::MODE_ENTERING_UP;
                end
            end else begin
                if (r_active) begin
                    n_mode = tfac_pkg::MODE_UP_ACTIVE;
                    if (r_countdown != 2'd0) begin
                        n_bg        = (r_countdown > 2'd1) ? tfac_pkg::BG_WARN
                                                           : tfac_pkg::BG_REINIT;
                        n_countdown = r_countdown - 2'd1;
                    end
                end else begin
                    n_mode = tfac_pkg::MODE_UP_SLEEP;
                end
                n_last_up = r_in_now;
            end
        end else begin
            n_beep = !r_inverted;
            if (r_active) begin
                n_down_work = !r_inverted;
                if (sleep_at < r_in_now) begin
                    n_active = 1'b0;
                    n_fw     = tfac_pkg::FW_CLEAR;
                    n_mode   = tfac_pkg::MODE_ENTERED_DOWN;
                end else if (keep_until > r_in_now) begin
                    n_mode = tfac_pkg::MODE_KEEP_ACTIVE;
                end else begin
                    n_mode = tfac_pkg::MODE_ENTERING_DOWN;
                end
            end else begin
                n_mode = tfac_pkg::MODE_DOWN_SLEEP;
            end
            n_inverted = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_inverted  <= 1'b0;
            r_last_up   <= '0;
            r_countdown <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_active    <= n_active;
                r_inverted  <= n_inverted;
                r_last_up   <= n_last_up;
                r_countdown <= n_countdown;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_open     <= i_switch_open;
            r_in_confirm  <= i_switch_open_confirm;
            r_in_now      <= i_now_seconds;
            r_in_enrolled <= i_stored_enrolled;
        end
        if (fire) begin
            r_mode         <= n_mode;
            r_down_work    <= n_down_work;
            r_beep         <= n_beep;
            r_bg           <= n_bg;
            r_fw           <= n_fw;
            r_active_now   <= n_active;
            r_inverted_now <= n_inverted;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_mode_action       = r_mode;
    assign o_entered_down_work = r_down_work;
    assign o_short_beep        = r_beep;
    assign o_background_step   = r_bg;
    assign o_flag_write        = r_fw;
    assign o_active_now        = r_active_now;
    assign o_inverted_now      = r_inverted_now;

    `TFAC_ASSERT_NEXT(a_no_drop, i_clk, i_rst_n, r_in_valid && !fire, r_in_valid)
    `TFAC_ASSERT_NEXT(a_down_sets_inverted, i_clk, i_rst_n, fire && !r_in_open, r_inverted)
    `TFAC_ASSERT_NOW(a_bg_only_up_active, i_clk, i_rst_n,
        o_valid && o_background_step != tfac_pkg::BG_NONE,
        o_mode_action == tfac_pkg::MODE_UP_ACTIVE)
    `TFAC_ASSERT_NOW(a_enroll_on_flip, i_clk, i_rst_n,
        o_valid && o_flag_write == tfac_pkg::FW_SET,
        o_mode_action == tfac_pkg::MODE_ENTERED_UP_WORK ||
        o_mode_action == tfac_pkg::MODE_ENTERING_UP)

endmodule

// ----- design/tfac_cfg_regs.sv -----
// Configuration register file for the tilt flip activation controller.
// Depends on tfac_pkg.
`timescale 1ns / 1ps

module tfac_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [tfac_pkg::CFG_IDX_W-1:0]    i_wr_index,
    input  logic [tfac_pkg::CFG_DATA_W-1:0]   i_wr_data,
    output tfac_pkg::t_cfg                    o_cfg
);

    tfac_pkg::t_cfg r_cfg;
    tfac_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                tfac_pkg::CFG_FLIP_WINDOW_MIN:   n_cfg.flip_window_min   = i_wr_data[7:0];
                tfac_pkg::CFG_REARM_WINDOW_MAX:  n_cfg.rearm_window_max  = i_wr_data[7:0];
                tfac_pkg::CFG_ENROLL_WINDOW_MAX: n_cfg.enroll_window_max = i_wr_data[7:0];
                tfac_pkg::CFG_SLEEP_TIMEOUT:     n_cfg.sleep_timeout     = i_wr_data;
                tfac_pkg::CFG_KEEP_ACTIVE_TIME:  n_cfg.keep_active_time  = i_wr_data;
                tfac_pkg::CFG_COUNTDOWN_START:   n_cfg.countdown_start   = i_wr_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flip_window_min   <= 8'd8;
            r_cfg.rearm_window_max  <= 8'd24;
            r_cfg.enroll_window_max <= 8'd12;
            r_cfg.sleep_timeout     <= 16'd900;
            r_cfg.keep_active_time  <= 16'd15;
            r_cfg.countdown_start   <= 2'd3;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/tfac_history.sv -----
// Flip time history: shift line of upright flip times and burst span.
// Depends on tfac_pkg.
`timescale 1ns / 1ps

module tfac_history #(
    parameter int DEPTH = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tfac_pkg::t_hist_ctrl            i_ctrl,
    input  logic [tfac_pkg::TIME_W-1:0]     i_now,
    output logic signed [tfac_pkg::TIME_W-1:0] o_span
);

    logic [tfac_pkg::TIME_W-1:0] r_flip [DEPTH];
    logic [tfac_pkg::TIME_W-1:0] n_flip [DEPTH];

    // span after the push: new newest is now, new oldest is entry 1
    assign o_span = $signed(i_now - r_flip[1]);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_flip[i] = r_flip[i];
        end
        if (i_ctrl.push) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_flip[i] = r_flip[i+1];
            end
            n_flip[DEPTH-1] = i_now;
        end
        if (i_ctrl.clear) begin
            for (int i = 0; i < DEPTH; i++) begin
                n_flip[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_flip[i] <= tfac_pkg::FLIP_TIME_RESET;
            end
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                r_flip[i] <= n_flip[i];
            end
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for tilt_flip_activation_controller.
// Keeps its own poll predictor and compares every result transaction with it.
// Depends on tfac_pkg and the controller RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int HIST_DEPTH  = 5;
    localparam int CYCLE_LIMIT = 200000;
    // index that maps to no register; writes to it must be ignored
    localparam logic [tfac_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic [3:0] mode_action;
        logic       entered_down_work;
        logic       short_beep;
        logic [1:0] background_step;
        logic [1:0] flag_write;
        logic       active_now;
        logic       inverted_now;
    } t_poll_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic                            i_switch_open = 1'b0;
    logic                            i_switch_open_confirm = 1'b0;
    logic [31:0]                     i_now_seconds = '0;
    logic                            i_stored_enrolled = 1'b0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic [3:0]                      o_mode_action;
    logic                            o_entered_down_work;
    logic                            o_short_beep;
    logic [1:0]                      o_background_step;
    logic [1:0]                      o_flag_write;
    logic                            o_active_now;
    logic                            o_inverted_now;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [tfac_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [tfac_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // tracked controller state and register copies
    logic        active_q;
    logic        inverted_q;
    logic [31:0] last_upright_s;
    logic [1:0]  bg_countdown;
    logic [31:0] flip_hist [HIST_DEPTH];
    logic [7:0]  cfg_fmin;
    logic [7:0]  cfg_rmax;
    logic [7:0]  cfg_emax;
    logic [15:0] cfg_sleep;
    logic [15:0] cfg_keep;
    logic [1:0]  cfg_cd;

    t_poll_result pending_results [$];
    t_poll_result want_q;
    t_poll_result got_q;
    int           mismatch_count = 0;
    int           polls_sent = 0;
    logic         calm = 1'b0;
    logic         nv_enrolled = 1'b0;
    logic [31:0]  sim_seconds = 32'd2000;

    tilt_flip_activation_controller dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_switch_open         (i_switch_open),
        .i_switch_open_confirm (i_switch_open_confirm),
        .i_now_seconds         (i_now_seconds),
        .i_stored_enrolled     (i_stored_enrolled),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_mode_action         (o_mode_action),
        .o_entered_down_work   (o_entered_down_work),
        .o_short_beep          (o_short_beep),
        .o_background_step     (o_background_step),
        .o_flag_write          (o_flag_write),
        .o_active_now          (o_active_now),
        .o_inverted_now        (o_inverted_now),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void fill_flip_hist(input logic [31:0] v);
        int i;
        for (i = 0; i < HIST_DEPTH; i++) flip_hist[i] = v;
    endfunction

    function automatic void reset_tracker();
        cfg_fmin       = 8'd8;
        cfg_rmax       = 8'd24;
        cfg_emax       = 8'd12;
        cfg_sleep      = 16'd900;
        cfg_keep       = 16'd15;
        cfg_cd         = 2'd3;
        active_q       = 1'b0;
        inverted_q     = 1'b0;
        last_upright_s = '0;
        bg_countdown   = '0;
        fill_flip_hist(tfac_pkg::FLIP_TIME_RESET);
    endfunction

    function automatic void apply_reg(input logic [tfac_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [tfac_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            tfac_pkg::CFG_FLIP_WINDOW_MIN:   cfg_fmin = data[7:0];
            tfac_pkg::CFG_REARM_WINDOW_MAX:  cfg_rmax = data[7:0];
            tfac_pkg::CFG_ENROLL_WINDOW_MAX: cfg_emax = data[7:0];
            tfac_pkg::CFG_SLEEP_TIMEOUT:     cfg_sleep = data;
            tfac_pkg::CFG_KEEP_ACTIVE_TIME:  cfg_keep = data;
            tfac_pkg::CFG_COUNTDOWN_START:   cfg_cd = data[1:0];
            default: ;
        endcase
    endfunction

    function automatic t_poll_result predict_poll_result(input logic open,
                                                         input logic confirm,
                                                         input logic [31:0] now,
                                                         input logic enrolled);
        t_poll_result r;
        int           span;
        int           i;
        logic [31:0]  deadline;
        r = '0;
        if (open) begin
            if (inverted_q) begin
                // re-read closed: flip not confirmed, nothing moves
                if (confirm) begin
                    for (i = 0; i < HIST_DEPTH - 1; i++) flip_hist[i] = flip_hist[i + 1];
                    flip_hist[HIST_DEPTH - 1] = now;
                    span = flip_hist[HIST_DEPTH - 1] - flip_hist[0];
                    if (enrolled) begin
                        active_q = 1'b1;
                        if (span < int'(cfg_rmax) && span > int'(cfg_fmin)) begin
                            bg_countdown = cfg_cd;
                            fill_flip_hist('0);
                        end
                    end else if (span < int'(cfg_emax) && span > int'(cfg_fmin)) begin
                        // enrollment keeps the previous active flag
                        r.flag_write = tfac_pkg::FW_SET;
                        fill_flip_hist('0);
                    end else begin
                        active_q = 1'b0;
                    end
                    r.mode_action = active_q ? tfac_pkg::MODE_ENTERED_UP_WORK
                                             : tfac_pkg::MODE_ENTERING_UP;
                    inverted_q = 1'b0;
                end
            end else begin
                if (active_q) begin
                    r.mode_action = tfac_pkg::MODE_UP_ACTIVE;
                    if (bg_countdown != 2'd0) begin
                        r.background_step = (bg_countdown > 2'd1) ? tfac_pkg::BG_WARN
                                                                  : tfac_pkg::BG_REINIT;
                        bg_countdown = bg_countdown - 2'd1;
                    end
                end else begin
                    r.mode_action = tfac_pkg::MODE_UP_SLEEP;
                end
                last_upright_s = now;
            end
        end else begin
            r.short_beep = !inverted_q;
            if (active_q) begin
                r.entered_down_work = !inverted_q;
                deadline = last_upright_s + {16'd0, cfg_sleep};
                if (deadline < now) begin
                    active_q = 1'b0;
                    r.flag_write = tfac_pkg::FW_CLEAR;
                    r.mode_action = tfac_pkg::MODE_ENTERED_DOWN;
                end else begin
                    deadline = last_upright_s + {16'd0, cfg_keep};
                    r.mode_action = (deadline > now) ? tfac_pkg::MODE_KEEP_ACTIVE
                                                     : tfac_pkg::MODE_ENTERING_DOWN;
                end
            end else begin
                r.mode_action = tfac_pkg::MODE_DOWN_SLEEP;
            end
            inverted_q = 1'b1;
        end
        r.active_now = active_q;
        r.inverted_now = inverted_q;
        return r;
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // mostly follows what the controller last wrote to the stored flag
    function automatic logic pick_enrolled();
        if ($urandom_range(99) < 10) return rand_bit();
        return nv_enrolled;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // receiver side
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 31);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_q = '{o_mode_action, o_entered_down_work, o_short_beep, o_background_step,
                      o_flag_write, o_active_now, o_inverted_now};
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatch_count++;
            end else begin
                want_q = pending_results.pop_front();
                check_field("mode_action", 32'(want_q.mode_action),
                            32'(got_q.mode_action));
                check_field("entered_down_work", 32'(want_q.entered_down_work),
                            32'(got_q.entered_down_work));
                check_field("short_beep", 32'(want_q.short_beep),
                            32'(got_q.short_beep));
                check_field("background_step", 32'(want_q.background_step),
                            32'(got_q.background_step));
                check_field("flag_write", 32'(want_q.flag_write),
                            32'(got_q.flag_write));
                check_field("active_now", 32'(want_q.active_now),
                            32'(got_q.active_now));
                check_field("inverted_now", 32'(want_q.inverted_now),
                            32'(got_q.inverted_now));
            end
        end
    end

    task automatic send_poll(input logic open, input logic confirm, input logic [31:0] now,
                             input logic enrolled);
        t_poll_result want;
        while (!calm && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid               <= 1'b1;
        i_switch_open         <= open;
        i_switch_open_confirm <= confirm;
        i_now_seconds         <= now;
        i_stored_enrolled     <= enrolled;
        do @(posedge i_clk); while (o_stall);
        want = predict_poll_result(open, confirm, now, enrolled);
        pending_results.push_back(want);
        if (want.flag_write == tfac_pkg::FW_SET) nv_enrolled = 1'b1;
        else if (want.flag_write == tfac_pkg::FW_CLEAR) nv_enrolled = 1'b0;
        polls_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] fmin, input logic [7:0] rmax,
                                input logic [7:0] emax, input logic [15:0] sleep,
                                input logic [15:0] keep, input logic [1:0] cd);
        logic [tfac_pkg::CFG_IDX_W-1:0]  idx_list [7];
        logic [tfac_pkg::CFG_DATA_W-1:0] dat_list [7];
        logic [13:0]                     junk;
        int                              k;
        drain();
        junk = 14'($urandom);
        // upper data bits above a register's width carry junk on purpose
        idx_list[0] = tfac_pkg::CFG_FLIP_WINDOW_MIN;   dat_list[0] = {junk[7:0], fmin};
        idx_list[1] = tfac_pkg::CFG_REARM_WINDOW_MAX;  dat_list[1] = {junk[13:6], rmax};
        idx_list[2] = tfac_pkg::CFG_ENROLL_WINDOW_MAX; dat_list[2] = {junk[10:3], emax};
        idx_list[3] = tfac_pkg::CFG_SLEEP_TIMEOUT;     dat_list[3] = sleep;
        idx_list[4] = tfac_pkg::CFG_KEEP_ACTIVE_TIME;  dat_list[4] = keep;
        idx_list[5] = tfac_pkg::CFG_COUNTDOWN_START;   dat_list[5] = {junk, cd};
        idx_list[6] = CFG_UNUSED_IDX;                  dat_list[6] = 16'($urandom);
        for (k = 0; k < 7; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= dat_list[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            apply_reg(idx_list[k], dat_list[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n);
        int          start;
        int          pick;
        int          s_span;
        int          hi;
        int          reps;
        int          j;
        int          k;
        int          off;
        logic [31:0] base;
        logic [31:0] t;
        start = polls_sent;
        while (polls_sent - start < n) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                // burst of five confirmed flips around the window limits
                hi = ((cfg_emax > cfg_rmax) ? int'(cfg_emax) : int'(cfg_rmax)) + 6;
                s_span = $urandom_range(0, hi);
                base = sim_seconds;
                for (k = 0; k < HIST_DEPTH; k++) begin
                    t = base + 32'((s_span * k) / 4);
                    if (!inverted_q || $urandom_range(99) < 20)
                        send_poll(1'b0, rand_bit(), t, pick_enrolled());
                    if ($urandom_range(99) < 10)
                        send_poll(1'b1, 1'b0, t, pick_enrolled());
                    send_poll(1'b1, 1'b1, t, pick_enrolled());
                end
                sim_seconds = base + 32'(s_span);
            end else if (pick < 65) begin
                // stay inverted, probing keep-active and sleep edges
                reps = $urandom_range(1, 4);
                for (j = 0; j < reps; j++) begin
                    case ($urandom_range(0, 6))
                        0: off = int'(cfg_keep) - 1;
                        1: off = int'(cfg_keep);
                        2: off = int'(cfg_keep) + 1;
                        3: off = int'(cfg_sleep) - 1;
                        4: off = int'(cfg_sleep);
                        5: off = int'(cfg_sleep) + 1;
                        default: off = $urandom_range(0, int'(cfg_sleep) + 20);
                    endcase
                    t = last_upright_s + 32'(off);
                    send_poll(1'b0, rand_bit(), t, pick_enrolled());
                    sim_seconds = t;
                end
            end else if (pick < 85) begin
                reps = $urandom_range(1, 5);
                for (j = 0; j < reps; j++) begin
                    sim_seconds = sim_seconds + $urandom_range(0, 3);
                    send_poll(1'b1, rand_bit(), sim_seconds, pick_enrolled());
                end
            end else if (pick < 95) begin
                send_poll(rand_bit(), rand_bit(), $urandom, rand_bit());
            end else if (pick < 98) begin
                // jump the clock, often right below the 32-bit wrap
                if ($urandom_range(0, 1)) sim_seconds = 32'hFFFF_FFFF - $urandom_range(0, 2000);
                else sim_seconds = $urandom;
            end else begin
                drain();
            end
        end
    endtask

    task automatic test_basic_modes();
        send_poll(1'b1, 1'b0, 32'd0, 1'b0);
        send_poll(1'b0, 1'b1, 32'd5, 1'b0);
        send_poll(1'b0, 1'b0, 32'd6, 1'b0);
        send_poll(1'b1, 1'b0, 32'd7, 1'b0);   // unconfirmed flip
        send_poll(1'b1, 1'b1, 32'd8, 1'b0);
        send_poll(1'b1, 1'b1, 32'd9, 1'b1);
        send_poll(1'b0, 1'b0, 32'd10, 1'b1);
        send_poll(1'b1, 1'b1, 32'd20, 1'b1);
        send_poll(1'b1, 1'b0, 32'd30, 1'b1);
        send_poll(1'b0, 1'b1, 32'd40, 1'b1);
        send_poll(1'b0, 1'b0, 32'd45, 1'b1);
        send_poll(1'b0, 1'b0, 32'd931, 1'b1); // sleep timeout passed
        send_poll(1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_enroll_burst();
        send_poll(1'b1, 1'b1, 32'd1000, 1'b0);
        send_poll(1'b0, 1'b0, 32'd1001, 1'b0);
        send_poll(1'b1, 1'b1, 32'd1002, 1'b0);
        send_poll(1'b0, 1'b0, 32'd1003, 1'b0);
        send_poll(1'b1, 1'b1, 32'd1005, 1'b0);
        send_poll(1'b0, 1'b0, 32'd1006, 1'b0);
        send_poll(1'b1, 1'b1, 32'd1007, 1'b0);
        send_poll(1'b0, 1'b0, 32'd1008, 1'b0);
        send_poll(1'b1, 1'b1, 32'd1010, 1'b0);
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        run_random(80);
        calm = 1'b0;
    endtask

    task automatic test_default_random();
        run_random(100);
    endtask

    task automatic test_zero_regs();
        program_regs(8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 2'd0);
        run_random(80);
    endtask

    task automatic test_max_regs();
        program_regs(8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 2'd3);
        run_random(80);
    endtask

    task automatic test_wide_windows();
        program_regs(8'd0, 8'd255, 8'd255, 16'd1, 16'd0, 2'd1);
        run_random(100);
    endtask

    task automatic test_random_regs();
        logic [7:0]  fmin;
        logic [15:0] sleep;
        fmin = 8'($urandom_range(0, 60));
        sleep = 16'($urandom_range(0, 3000));
        program_regs(fmin, 8'(32'(fmin) + $urandom_range(2, 80)),
                     8'(32'(fmin) + $urandom_range(2, 60)),
                     sleep, 16'($urandom_range(0, 32'(sleep))),
                     2'($urandom_range(0, 3)));
        run_random(100);
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        reset_tracker();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_modes();
        test_enroll_burst();
        test_back_to_back();
        test_default_random();
        test_zero_regs();
        test_max_regs();
        test_wide_windows();
        test_random_regs();
        test_random_regs();
        drain();
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d result transactions never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
